// ----- rtl/pbec_pkg.sv -----
// Shared types, constants and helper functions for the packet bit-error counter.
// Depends on nothing; pbec_accum and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package pbec_pkg;

  localparam int REF_DEPTH = 256;
  localparam int REF_AW    = $clog2(REF_DEPTH);
  localparam int POS_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int POP_W     = 4;
  localparam int RUN_BITS_W = 12;
  localparam int RUN_CNT_W  = 9;
  localparam int TOTAL_W    = 32;
  localparam int RESULT_W   = RUN_BITS_W + RUN_CNT_W + 5 * TOTAL_W;
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_RECV  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              last;
    logic              crc_good;
    logic [BYTE_W-1:0] data;
  } beat_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]    bit_errors_caught;
    logic [TOTAL_W-1:0]    bit_errors_total;
    logic [TOTAL_W-1:0]    bytes_seen;
    logic [TOTAL_W-1:0]    packets_clean;
    logic [TOTAL_W-1:0]    packets_seen;
    logic [RUN_CNT_W-1:0]  packet_byte_errors;
    logic [RUN_BITS_W-1:0] packet_bit_errors;
  } result_t;

  function automatic logic [REF_AW-1:0] ref_index(input logic [POS_W-1:0] pos);
    return REF_AW'(32'(pos) % REF_DEPTH);
  endfunction

  function automatic logic [POP_W-1:0] pop8(input logic [BYTE_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add32(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pbec_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module pbec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pbec_accum.sv -----
// Per-packet run counters and saturating running totals of the error counter.
// Depends on pbec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbec_accum import pbec_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire beat_t             beat,
  input  wire logic [BYTE_W-1:0] ref_byte,
  output logic                   emit,
  output result_t                result
);

  localparam logic [RUN_BITS_W-1:0] RUN_BITS_MAX = {RUN_BITS_W{1'b1}};
  localparam logic [RUN_CNT_W-1:0]  RUN_CNT_MAX  = {RUN_CNT_W{1'b1}};

  logic [RUN_BITS_W-1:0] run_bits;
  logic [RUN_CNT_W-1:0]  run_byte_errs;
  logic [RUN_CNT_W-1:0]  run_bytes;
  logic [TOTAL_W-1:0]    total_packets;
  logic [TOTAL_W-1:0]    total_clean;
  logic [TOTAL_W-1:0]    total_bytes;
  logic [TOTAL_W-1:0]    total_bits;
  logic [TOTAL_W-1:0]    total_caught;

  logic [BYTE_W-1:0]     diff;
  logic [RUN_BITS_W:0]   bits_sum;
  logic [RUN_BITS_W-1:0] run_bits_next;
  logic [RUN_CNT_W-1:0]  run_byte_errs_next;
  logic [RUN_CNT_W-1:0]  run_bytes_next;
  logic                  is_recv;

  always_comb begin
    diff     = beat.data ^ ref_byte;
    bits_sum = {1'b0, run_bits} + (RUN_BITS_W + 1)'(pop8(diff));
    run_bits_next = bits_sum[RUN_BITS_W] ? RUN_BITS_MAX : bits_sum[RUN_BITS_W-1:0];
    run_byte_errs_next = run_byte_errs;
    if ((diff != '0) && (run_byte_errs != RUN_CNT_MAX)) begin
      run_byte_errs_next = run_byte_errs + 1'b1;
    end
    run_bytes_next = (run_bytes == RUN_CNT_MAX) ? RUN_CNT_MAX : run_bytes + 1'b1;
    is_recv = (beat.cmd == CMD_RECV);
    emit    = fire && is_recv && beat.last;

    result.packet_bit_errors  = run_bits_next;
    result.packet_byte_errors = run_byte_errs_next;
    result.packets_seen       = sat_add32(total_packets, TOTAL_W'(1));
    result.packets_clean      = (run_bits_next == '0) ?
                                sat_add32(total_clean, TOTAL_W'(1)) : total_clean;
    result.bytes_seen         = sat_add32(total_bytes, TOTAL_W'(run_bytes_next));
    result.bit_errors_total   = sat_add32(total_bits, TOTAL_W'(run_bits_next));
    result.bit_errors_caught  = beat.crc_good ? total_caught :
                                sat_add32(total_caught, TOTAL_W'(run_bits_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_bits      <= '0;
      run_byte_errs <= '0;
      run_bytes     <= '0;
      total_packets <= '0;
      total_clean   <= '0;
      total_bytes   <= '0;
      total_bits    <= '0;
      total_caught  <= '0;
    end else if (fire) begin
      case (beat.cmd)
        CMD_CLEAR: begin
          total_packets <= '0;
          total_clean   <= '0;
          total_bytes   <= '0;
          total_bits    <= '0;
          total_caught  <= '0;
        end
        CMD_RECV: begin
          if (beat.last) begin
            run_bits      <= '0;
            run_byte_errs <= '0;
            run_bytes     <= '0;
            total_packets <= result.packets_seen;
            total_clean   <= result.packets_clean;
            total_bytes   <= result.bytes_seen;
            total_bits    <= result.bit_errors_total;
            total_caught  <= result.bit_errors_caught;
          end else begin
            run_bits      <= run_bits_next;
            run_byte_errs <= run_byte_errs_next;
            run_bytes     <= run_bytes_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (fire && beat.cmd == CMD_CLEAR) |=> (total_packets == '0 && total_bits == '0))
    else $error("totals not cleared after a clear beat");

  a_run_restart: assert property (@(posedge clk) disable iff (rst)
    emit |=> (run_bits == '0 && run_bytes == '0 && run_byte_errs == '0))
    else $error("run counters not restarted after the last beat");

  a_byte_errs_bound: assert property (@(posedge clk) disable iff (rst)
    run_byte_errs <= run_bytes)
    else $error("byte errors exceed bytes in the packet");

endmodule

`default_nettype wire

// ----- rtl/packet_bit_error_counter_unit.sv -----
// Top level of the packet bit-error counter: input stage, reference RAM,
// counters and the result register. Depends on pbec_pkg, pbec_ram, pbec_accum.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one beat per clock cycle unless stalled. A load beat writes a
// reference byte, a clear beat zeroes the totals, and a received beat is compared
// with the reference byte at its position. A received beat with tlast set produces
// one result beat: the beat and its registered reference RAM read are held in the
// compare stage, and the result is then captured in the output register. The input
// is stalled only while a finished result waits in the output register and the beat
// in the compare stage needs that register too.

module packet_bit_error_counter_unit import pbec_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [15:0]           s_tdata,  // byte_pos, data_byte
  input  wire logic [2:0]            s_tuser,  // command[1:0], crc_good
  input  wire logic                  s_tlast,  // last_byte
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata   // packet_bit_errors, packet_byte_errors,
                                               // packets_seen, packets_clean,
                                               // bytes_seen, bit_errors_total,
                                               // bit_errors_caught, zero fill
);

  logic              accept;
  logic              fire;
  logic              stage_valid;
  beat_t             stage_beat;
  beat_t             in_beat;
  logic [REF_AW-1:0] in_idx;
  logic [BYTE_W-1:0] ref_byte;
  logic              emit;
  logic              needs_out;
  result_t           result;
  result_t           out_reg;

  always_comb begin
    in_beat.cmd      = cmd_t'(s_tuser[1:0]);
    in_beat.crc_good = s_tuser[2];
    in_beat.last     = s_tlast;
    in_beat.data     = s_tdata[15:8];
    in_idx           = ref_index(s_tdata[7:0]);
    needs_out        = (stage_beat.cmd == CMD_RECV) && stage_beat.last;
    s_tready         = !stage_valid || !needs_out || !m_tvalid || m_tready;
    accept           = s_tvalid && s_tready;
    fire             = stage_valid && s_tready;
  end

  pbec_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(REF_DEPTH)
  ) u_ref_ram (
    .clk  (clk),
    .we   (accept && in_beat.cmd == CMD_LOAD),
    .waddr(in_idx),
    .wdata(in_beat.data),
    .re   (accept),
    .raddr(in_idx),
    .rdata(ref_byte)
  );

  pbec_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .beat    (stage_beat),
    .ref_byte(ref_byte),
    .emit    (emit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (s_tready) begin
        stage_valid <= s_tvalid;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (accept) begin
      stage_beat <= in_beat;
    end
    if (emit) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {(OUT_DATA_W - RESULT_W)'(0), out_reg};

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> $past(emit))
    else $error("result beat without a finished packet");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && stage_valid))
    else $error("input stalled without a waiting result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !emit)
    else $error("waiting result overwritten");

endmodule

`default_nettype wire
